>>> src/mhs_pkg.sv
`default_nettype none
package mhs_pkg;
    localparam int LOG_FRAC = 30;
    localparam logic [26:0] LN2_Q26 = 27'd46516320;
    localparam int TENURE_MIN = 3;

    // log unit request
    typedef struct packed {
        logic        start;
        logic [47:0] x;
    } t_log_req;

    typedef struct packed {
        logic        done;
        logic [35:0] r;
    } t_log_rsp;
endpackage
`default_nettype wire

>>> src/mhs_log2.sv
`default_nettype none
// log2 of an integer x >= 1, 30 fraction bits, one squaring per cycle
module mhs_log2 (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mhs_pkg::t_log_req   i_req,
    output mhs_pkg::t_log_rsp   o_rsp
);
    import mhs_pkg::*;

    logic        r_busy, n_busy;
    logic [4:0]  r_bit, n_bit;
    logic [31:0] r_m, n_m;
    logic [35:0] r_r, n_r;
    logic        r_done, n_done;
    logic [5:0]  lead;
    logic [63:0] sq;
    logic [79:0] wide;

    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < 48; i++)
            if (i_req.x[i]) lead = 6'(i);
    end

    assign sq = 64'(r_m) * 64'(r_m);

    always_comb begin
        n_busy = r_busy;
        n_bit  = r_bit;
        n_m    = r_m;
        n_r    = r_r;
        n_done = 1'b0;
        wide   = 80'(i_req.x) << 30;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_bit  = 5'd29;
            n_m    = 32'((wide >> lead));
            n_r    = {lead, 30'd0};
        end else if (r_busy) begin
            n_m = sq[61:30];
            // square reached [2, 4): renormalize and emit a one
            if (sq[61]) begin
                n_m = sq[62:31];
                n_r[r_bit] = 1'b1;
            end
            if (r_bit == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_bit = r_bit - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_bit <= n_bit;
        r_m   <= n_m;
        r_r   <= n_r;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.r    = r_r;
endmodule
`default_nettype wire

>>> src/mhs_div.sv
`default_nettype none
// unsigned restoring divider, one quotient bit per cycle
module mhs_div #(
    parameter int NW = 60,
    parameter int DW = 36
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire [NW-1:0]  i_num,
    input  wire [DW-1:0]  i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic          r_done;
    logic [DW:0]   trial;

    assign trial = {r_rem[DW-1:0], r_q[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_den}) begin
                    r_rem <= trial - {1'b0, r_den};
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

>>> src/momentum_heuristic_switch.sv
`default_nettype none
// channel  | dir | tdata bits (low first)                          | tuser
// s_axis   | in  | phase_conflicts[31:0] decisions[63:32] tick[111:64] | -
// m_axis   | out | reward_total[39:0] selections[71:40] (pad to 72)  | active, switched
// cfg      | in  | switching_enabled                                  | -
// A request with a reward passes from accept to the next accept through three log2
// passes on the shared log unit (conflicts, elapsed ticks, decisions), three update
// steps, a serial divide and one output step. Without a reward the decisions pass
// and the divide are skipped, with no conflicts also the first two log2 passes, and
// with switching disabled only the output step is left. s_axis_tready is low meanwhile.
// Synchronous active-low reset; the result sits in an output register, and a
// stalled master side holds it while the next request may still enter; that
// request then waits in its output step until the register is taken.
module momentum_heuristic_switch #(
    parameter int FRACTION_BITS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_wdata,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire [111:0]  s_axis_tdata,   // conflicts, decisions, tick_now
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // reward_total, selections
    output logic [1:0]   m_axis_tuser    // active_heuristic, switched
);
    import mhs_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int AW = 6 + F + 1;
    localparam int SH = LOG_FRAC + 26 - F;
    localparam int NW = 36 + F;
    localparam logic signed [AW-1:0] QHI = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] QLO = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [AW+1:0] BUF = (AW+2)'((64'd3277 << F) + 64'd32768 >> 16);

    localparam logic [3:0] S_IDLE = 4'd0, S_LOGC = 4'd1, S_WC = 4'd2, S_LOGE = 4'd3,
                           S_WE = 4'd4, S_YLD = 4'd5, S_EMA = 4'd6, S_PRJ = 4'd7,
                           S_LOGD = 4'd8, S_WD = 4'd9, S_DIV = 4'd10, S_WDV = 4'd11,
                           S_OUT = 4'd12;

    logic [3:0]  r_st;
    logic        r_en;
    logic [31:0] r_conf, r_dec;
    logic [47:0] r_last, r_elap;
    logic [35:0] r_lc, r_le;
    logic signed [AW-1:0] r_fast [2];
    logic signed [AW-1:0] r_slow [2];
    logic [1:0]  r_seed;
    logic [1:0]  r_ten;
    logic        r_cur;
    logic [39:0] r_rew [2];
    logic [31:0] r_sel [2];
    logic signed [AW-1:0] r_y;
    logic        r_sw;
    logic        r_ov;
    logic [71:0] r_odata;
    logic [1:0]  r_ouser;
    logic        out_load;

    t_log_req log_req;
    t_log_rsp log_rsp;
    logic     div_start, div_done;
    logic [NW-1:0] div_q;

    mhs_log2 u_log (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(log_req), .o_rsp(log_rsp));
    mhs_div #(.NW(NW), .DW(36)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(NW'({r_le, F'(0)}) + NW'(r_lc >> 1)), .i_den(r_lc),
        .o_done(div_done), .o_quo(div_q));

    logic inc;
    assign inc = r_cur;

    function automatic logic signed [79:0] rshift(input logic signed [79:0] v, input int s);
        logic [79:0] mag;
        mag = v[79] ? 80'(-v) : 80'(v);
        mag = (mag + (80'd1 << (s - 1))) >> s;
        return v[79] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [AW-1:0] satq(input logic signed [79:0] v);
        if (v > 80'(QHI)) return QHI;
        if (v < 80'(QLO)) return QLO;
        return AW'(v);
    endfunction

    function automatic logic signed [AW+1:0] proj(input logic signed [AW-1:0] fa,
                                                  input logic signed [AW-1:0] sa);
        logic signed [79:0] m;
        m = 80'(fa) - 80'(sa);
        return (AW+2)'(satq(80'(fa) + rshift(3 * m, 1)));
    endfunction

    // combinational pieces of the work
    logic signed [79:0] diff, yprod;
    logic signed [79:0] fprod, sprod;
    logic signed [AW+1:0] pinc, pchal, momv;
    assign diff  = $signed(80'(r_lc)) - $signed(80'(r_le));
    assign yprod = diff * $signed({53'd0, LN2_Q26});
    assign fprod = 80'sd13107 * 80'(r_y) + 80'sd52429 * 80'(r_fast[inc]);
    assign sprod = 80'sd3277 * 80'(r_y) + 80'sd62259 * 80'(r_slow[inc]);
    assign momv  = (AW+2)'(r_fast[inc]) - (AW+2)'(r_slow[inc]);
    assign pinc  = proj(r_fast[inc], r_slow[inc]);
    assign pchal = proj(r_fast[~inc], r_slow[~inc]);

    logic [40:0] rsum;
    assign rsum = 41'(r_rew[inc]) + 41'(div_q);

    always_comb begin
        log_req.start = 1'b0;
        log_req.x     = 48'(r_conf);
        div_start     = 1'b0;
        case (r_st)
            S_LOGC: log_req.start = 1'b1;
            S_LOGE: begin log_req.start = 1'b1; log_req.x = r_elap; end
            S_LOGD: begin log_req.start = 1'b1; log_req.x = 48'(r_dec); end
            S_DIV:  div_start = 1'b1;
            default: ;
        endcase
    end

    assign s_axis_tready = (r_st == S_IDLE);
    assign out_load = (r_st == S_OUT) && (!r_ov || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_en   <= 1'b1;
            r_last <= '0;
            r_seed <= '0;
            r_ten  <= '0;
            r_cur  <= 1'b0;
            r_fast[0] <= '0; r_fast[1] <= '0;
            r_slow[0] <= '0; r_slow[1] <= '0;
            r_rew[0]  <= '0; r_rew[1]  <= '0;
            r_sel[0]  <= '0; r_sel[1]  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) r_en <= i_cfg_wdata;
            if (out_load) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (s_axis_tvalid) begin
                    r_conf <= s_axis_tdata[31:0];
                    r_dec  <= s_axis_tdata[63:32];
                    r_elap <= (s_axis_tdata[111:64] - r_last == 48'd0) ? 48'd1
                              : s_axis_tdata[111:64] - r_last;
                    r_sw   <= 1'b0;
                    r_st   <= r_en ? (s_axis_tdata[31:0] == 32'd0 ? S_YLD : S_LOGC) : S_OUT;
                    if (r_en && s_axis_tdata[31:0] == 32'd0)
                        r_y <= -AW'(20 <<< F);
                    if (r_en) r_last <= s_axis_tdata[111:64];
                end
                S_LOGC: r_st <= S_WC;
                S_WC: if (log_rsp.done) begin r_lc <= log_rsp.r; r_st <= S_LOGE; end
                S_LOGE: r_st <= S_WE;
                S_WE: if (log_rsp.done) begin r_le <= log_rsp.r; r_st <= S_YLD; end
                S_YLD: begin
                    if (r_conf != 32'd0) r_y <= satq(rshift(yprod, SH));
                    r_st <= S_EMA;
                end
                S_EMA: begin
                    if (!r_seed[inc]) begin
                        r_fast[inc] <= r_y;
                        r_slow[inc] <= r_y;
                        r_seed[inc] <= 1'b1;
                    end else begin
                        r_fast[inc] <= AW'(rshift(fprod, 16));
                        r_slow[inc] <= AW'(rshift(sprod, 16));
                    end
                    r_st <= S_PRJ;
                end
                S_PRJ: begin
                    if (r_ten < 2'(TENURE_MIN)) r_ten <= r_ten + 2'd1;
                    else if (pchal > pinc + (momv < 0 ? (AW+2)'(0) : BUF)) r_sw <= 1'b1;
                    if (r_sel[inc] != 32'hFFFF_FFFF) r_sel[inc] <= r_sel[inc] + 32'd1;
                    r_st <= (r_conf > 32'd1 && r_dec != 32'd0) ? S_LOGD : S_OUT;
                end
                S_LOGD: r_st <= S_WD;
                // r_le now reused for log2(decisions)
                S_WD: if (log_rsp.done) begin r_le <= log_rsp.r; r_st <= S_DIV; end
                S_DIV: r_st <= S_WDV;
                S_WDV: if (div_done) begin
                    // reward = round(num/den) = floor((num + den/2)/den): half added into the numerator
                    r_rew[inc] <= rsum > 41'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : rsum[39:0];
                    r_st <= S_OUT;
                end
                S_OUT: if (out_load) begin
                    r_odata <= {r_sel[inc], r_rew[inc]};
                    r_ouser <= {r_sw, r_sw ? ~r_cur : r_cur};
                    if (r_sw) begin r_cur <= ~r_cur; r_ten <= '0; end
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
endmodule
`default_nettype wire

>>> src/mhs_checker.sv
`default_nettype none
module mhs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [71:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser
);
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready) else $error("reset state");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("took two");
endmodule
bind momentum_heuristic_switch mhs_checker u_chk (.*);
`default_nettype wire

>>> sim/momentum_heuristic_switch_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module momentum_heuristic_switch_tb;
    localparam int FB = 16;
    localparam int LOGF = 30;
    localparam longint LN2C = 46516320;
    localparam logic [39:0] REW_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] SEL_MAX = 32'hFFFF_FFFF;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 850;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_wdata = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;   // conflicts[31:0], decisions[63:32], tick[111:64]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;        // reward_total[39:0], selections[71:40]
    logic [1:0]   m_axis_tuser;        // active[0], switched[1]

    momentum_heuristic_switch #(.FRACTION_BITS(FB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct packed {
        logic        active;
        logic        switched;
        logic [39:0] reward;
        logic [31:0] selections;
    } t_decision;

    typedef struct {
        logic [31:0] conflicts;
        logic [31:0] decisions;
        logic [47:0] tick;
        logic        check_typed;
        t_decision   typed;
    } t_phase_row;

    // switch model state
    logic          sw_enabled;
    longint        fast_avg [2];
    longint        slow_avg [2];
    logic          seeded [2];
    logic [47:0]   last_tick;
    int            tenure;
    logic          choice;
    logic [39:0]   reward_sum [2];
    logic [31:0]   select_sum [2];

    t_decision     pending_decisions [$];
    int            mismatches = 0;
    int            decisions_seen = 0;
    int            idle_cycles = 0;
    int            switches_seen = 0;
    bit            quiet_mode = 1'b0;

    function automatic longint rnd_shift(longint v, int s);
        longint mag;
        mag = v < 0 ? -v : v;
        mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
        return v < 0 ? -mag : mag;
    endfunction

    function automatic longint sat_q(longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (6 + FB)) - 1;
        lo = -(longint'(1) <<< (6 + FB));
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint unsigned log2_q30(longint unsigned x);
        int n;
        longint unsigned m, r;
        n = 0;
        for (int b = 63; b >= 0; b--) begin
            if (x[b] && n == 0 && b > 0) n = b;
        end
        m = n >= LOGF ? x >> (n - LOGF) : x << (LOGF - n);
        r = longint'(n) << LOGF;
        for (int i = LOGF - 1; i >= 0; i--) begin
            m = (m * m) >> LOGF;
            if (m >= (64'd1 << (LOGF + 1))) begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic longint projected(int h);
        return sat_q(fast_avg[h] + rnd_shift(3 * (fast_avg[h] - slow_avg[h]), 1));
    endfunction

    function automatic t_decision evaluate_phase(logic [31:0] cf, logic [31:0] dc,
                                                  logic [47:0] now);
        t_decision d;
        int inc, chal;
        logic [47:0] elapsed;
        longint y, mom, buffer, diff;
        longint unsigned num, den, rew, sum;
        bit do_sw;
        inc = int'(choice);
        chal = 1 - inc;
        do_sw = 1'b0;
        if (sw_enabled) begin
            elapsed = now - last_tick;
            last_tick = now;
            if (elapsed == 0) elapsed = 48'd1;
            if (cf == 0) y = -(longint'(20) <<< FB);
            else begin
                diff = longint'(log2_q30(64'(cf))) - longint'(log2_q30(64'(elapsed)));
                y = sat_q(rnd_shift(diff * LN2C, LOGF + 26 - FB));
            end
            if (!seeded[inc]) begin
                fast_avg[inc] = y;
                slow_avg[inc] = y;
                seeded[inc] = 1'b1;
            end else begin
                fast_avg[inc] = rnd_shift(13107 * y + 52429 * fast_avg[inc], 16);
                slow_avg[inc] = rnd_shift(3277 * y + 62259 * slow_avg[inc], 16);
            end
            mom = fast_avg[inc] - slow_avg[inc];
            buffer = mom < 0 ? 0 : rnd_shift(longint'(3277) <<< FB, 16);
            if (tenure < 3) tenure++;
            else if (projected(chal) > projected(inc) + buffer) do_sw = 1'b1;
            if (cf > 1 && dc > 0) begin
                num = log2_q30(64'(dc)) << FB;
                den = log2_q30(64'(cf));
                rew = (num + den / 2) / den;
                sum = reward_sum[inc] + rew;
                reward_sum[inc] = sum > REW_MAX ? REW_MAX : sum[39:0];
            end
            if (select_sum[inc] != SEL_MAX) select_sum[inc]++;
            if (do_sw) begin
                choice = 1'(chal);
                tenure = 0;
            end
        end
        d.active = choice;
        d.switched = do_sw;
        d.reward = reward_sum[inc];
        d.selections = select_sum[inc];
        return d;
    endfunction

    task automatic reset_model();
        sw_enabled = 1'b1;
        for (int h = 0; h < 2; h++) begin
            fast_avg[h] = 0;
            slow_avg[h] = 0;
            seeded[h] = 1'b0;
            reward_sum[h] = '0;
            select_sum[h] = '0;
        end
        last_tick = '0;
        tenure = 0;
        choice = 1'b0;
    endtask

    task automatic report_mismatch(t_decision exp_d, t_decision act_d);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: exp act=%0d sw=%0d rew=%0h sel=%0d",
                     $time, exp_d.active, exp_d.switched, exp_d.reward, exp_d.selections);
            $display("    got act=%0d sw=%0d rew=%0h sel=%0d",
                     act_d.active, act_d.switched, act_d.reward, act_d.selections);
        end
    endtask

    // result side: random backpressure and scoreboard
    always @(posedge i_clk) begin
        t_decision got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.active = m_axis_tuser[0];
            got.switched = m_axis_tuser[1];
            got.reward = m_axis_tdata[39:0];
            got.selections = m_axis_tdata[71:40];
            decisions_seen++;
            if (got.switched) switches_seen++;
            if (pending_decisions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $time);
            end else begin
                want = pending_decisions.pop_front();
                if (got != want) report_mismatch(want, got);
            end
        end
        m_axis_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 26);
    end

    // watchdog on stalled progress
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog expired at %0t", $time);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_phase(logic [31:0] cf, logic [31:0] dc, logic [47:0] now,
                              bit check_typed, t_decision typed);
        t_decision d;
        if (!quiet_mode) begin
            while ($urandom_range(99) < 26) @(posedge i_clk);
        end
        s_axis_tdata <= {now, dc, cf};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        d = evaluate_phase(cf, dc, now);
        if (check_typed && d != typed) report_mismatch(typed, d);
        pending_decisions.push_back(d);
        // the block is never ready right after an accept
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_enable(logic v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sw_enabled = v;
    endtask

    function automatic logic [31:0] pick_count();
        case ($urandom_range(5))
            0: return $urandom_range(3);
            1: return $urandom;
            2: return SEL_MAX - $urandom_range(3);
            default: return $urandom_range(20000);
        endcase
    endfunction

    t_phase_row phase_rows [$];
    logic [47:0] tick_now;

    initial begin
        t_decision none;
        none = '0;
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first rows readable at a glance, then extremes
        phase_rows.push_back('{32'd0, 32'd0, 48'd0, 1'b1, '{1'b0, 1'b0, 40'd0, 32'd1}});
        phase_rows.push_back('{32'd1, 32'd5, 48'd100, 1'b1, '{1'b0, 1'b0, 40'd0, 32'd2}});
        phase_rows.push_back('{32'd2, 32'd0, 48'd100, 1'b1, '{1'b0, 1'b0, 40'd0, 32'd3}});
        // tenure reached, unseeded challenger at zero beats an incumbent projected below zero
        phase_rows.push_back('{32'd2, 32'd2, 48'd300, 1'b1, '{1'b1, 1'b1, 40'h10000, 32'd4}});
        phase_rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, none});
        phase_rows.push_back('{32'h8000_0000, 32'd1, 48'd5, 1'b0, none});
        phase_rows.push_back('{32'd3, 32'hFFFF_FFFF, 48'h8000_0000_0000, 1'b0, none});
        phase_rows.push_back('{32'hFFFF_FFFF, 32'd7, 48'h8000_0000_0001, 1'b0, none});
        for (int k = 0; k < 8; k++)
            phase_rows.push_back('{32'd0, 32'd9, 48'h8000_0000_0100 + 48'(k * 1000), 1'b0,
                                   none});
        phase_rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 48'h5555_5555_5555, 1'b0, none});
        phase_rows.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, none});
        foreach (phase_rows[r])
            send_phase(phase_rows[r].conflicts, phase_rows[r].decisions, phase_rows[r].tick,
                       phase_rows[r].check_typed, phase_rows[r].typed);

        write_enable(1'b0);
        send_phase(32'd50, 32'd60, 48'd12345, 1'b0, none);
        send_phase(32'd0, 32'd0, 48'd0, 1'b0, none);
        write_enable(1'b1);

        tick_now = 48'd1000;
        for (int n = 0; n < N_RANDOM; n++) begin
            logic [31:0] cf, dc;
            if (n == 300) drain();  // sender holds off until all results are in
            quiet_mode = (n >= 400 && n < 500);
            if (n == 600) write_enable(1'b0);
            if (n == 640) write_enable(1'b1);
            cf = pick_count();
            dc = pick_count();
            case ($urandom_range(9))
                0: tick_now = 48'({$urandom, $urandom});
                1: ;
                2: tick_now = tick_now - 48'($urandom_range(1000));
                default: tick_now = tick_now + 48'($urandom_range(200000));
            endcase
            send_phase(cf, dc, tick_now, 1'b0, none);
        end
        quiet_mode = 1'b0;
        drain();

        $display("%0d phase results checked, %0d switches observed, enable toggled off and on",
                 decisions_seen, switches_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
